FILE: design/lcau_pkg.sv
`default_nettype none
package lcau_pkg;

  localparam int unsigned CostW   = 16;
  localparam int unsigned IntInW  = 31;
  localparam int unsigned IntOutW = 64;

  localparam logic [CostW-1:0] NearGap = 16'd31;
  localparam logic [CostW-1:0] FarGap  = 16'd49;

  // reciprocal of ten: q = (c * Recip10) >> Recip10Sh, exact for 16-bit c
  localparam logic [16:0] Recip10   = 17'd52429;
  localparam int unsigned Recip10Sh = 19;

  // largest quotient whose shifted value still fits 64 bits
  localparam logic [13:0] MaxQuot = 14'd63;

  typedef enum logic [1:0] {
    OP_MUL      = 2'd0,
    OP_ADD      = 2'd1,
    OP_FROM_INT = 2'd2,
    OP_TO_INT   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CostW-1:0]  cost_a;
    logic [CostW-1:0]  cost_b;
    logic [IntInW-1:0] int_value;
  } req_t;

  typedef struct packed {
    logic [CostW-1:0]   cost_result;
    logic [IntOutW-1:0] int_result;
    logic               overflow;
  } rsp_t;

  function automatic logic [3:0] corr_lut(input logic [4:0] idx);
    logic [3:0] v;
    case (idx)
      5'd0, 5'd1:                           v = 4'd10;
      5'd2, 5'd3:                           v = 4'd9;
      5'd4, 5'd5:                           v = 4'd8;
      5'd6, 5'd7, 5'd8:                     v = 4'd7;
      5'd9, 5'd10, 5'd11:                   v = 4'd6;
      5'd12, 5'd13, 5'd14:                  v = 4'd5;
      5'd15, 5'd16, 5'd17, 5'd18:           v = 4'd4;
      5'd19, 5'd20, 5'd21, 5'd22, 5'd23,
      5'd24:                                v = 4'd3;
      default:                              v = 4'd2;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] mant_lut(input logic [2:0] idx);
    logic [3:0] v;
    case (idx)
      3'd0:    v = 4'd0;
      3'd1:    v = 4'd2;
      3'd2:    v = 4'd3;
      3'd3:    v = 4'd5;
      3'd4:    v = 4'd6;
      3'd5:    v = 4'd7;
      3'd6:    v = 4'd8;
      default: v = 4'd9;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: design/log_cost_arithmetic_unit.sv
// Log-cost arithmetic unit: multiply, add, integer-to-cost and cost-to-integer on
// 16-bit costs (ten times log2). One item is accepted per clock with no bubbles
// while out_stall is low; each result passes through the input register and then
// the result register before it is presented on out_data.
// The path between them is set by the divide-by-ten reciprocal multiply feeding
// the 64-bit shifter of cost-to-integer. Stall from the result side backs up
// through both registers to in_stall.
`default_nettype none
module log_cost_arithmetic_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire lcau_pkg::req_t  in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output lcau_pkg::rsp_t       out_data
);

  logic           s1_vld_r, s2_vld_r;
  lcau_pkg::req_t s1_req_r;
  lcau_pkg::rsp_t s2_rsp_r, s2_rsp_nxt;
  logic           s1_ld, s2_ld;

  assign s2_ld    = s1_vld_r && (!s2_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s2_ld;
  assign s1_ld    = in_valid && !in_stall;

  lcau_core u_core (
    .req (s1_req_r),
    .rsp (s2_rsp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_ld) begin
        s1_vld_r <= 1'b1;
      end else if (s2_ld) begin
        s1_vld_r <= 1'b0;
      end
      if (s2_ld) begin
        s2_vld_r <= 1'b1;
      end else if (!out_stall) begin
        s2_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_req_r <= in_data;
    end
    if (s2_ld) begin
      s2_rsp_r <= s2_rsp_nxt;
    end
  end

  assign out_valid = s2_vld_r;
  assign out_data  = s2_rsp_r;

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s2_vld_r && out_stall |-> in_stall)
    else $error("input not stalled with both stages full");

  a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ld |=> s1_vld_r)
    else $error("accepted item lost from input stage");

  a_s2_fill: assert property (@(posedge clk) disable iff (!rst_n)
    s2_ld |=> s2_vld_r)
    else $error("moved item lost from result stage");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> out_data.int_result == '1 &&
    out_data.cost_result == '0)
    else $error("overflow without saturated result");

endmodule
`default_nettype wire

FILE: design/lcau_core.sv
`default_nettype none
module lcau_core (
  input  wire lcau_pkg::req_t req,
  output lcau_pkg::rsp_t      rsp
);

  // add
  logic [15:0] hi, lo, gap, add_res;

  always_comb begin
    if (req.cost_a > req.cost_b) begin
      hi = req.cost_a;
      lo = req.cost_b;
    end else begin
      hi = req.cost_b;
      lo = req.cost_a;
    end
    gap = hi - lo;
    if (gap > lcau_pkg::FarGap) begin
      add_res = hi;
    end else if (gap > lcau_pkg::NearGap) begin
      add_res = hi + 16'd1;
    end else begin
      add_res = hi + {12'd0, lcau_pkg::corr_lut(gap[4:0])};
    end
  end

  // integer to cost: leading-one position p, result MANT + 10*p
  logic [4:0]  lead;
  logic [33:0] norm_w;
  logic [33:0] norm_sh;
  logic [15:0] from_res;

  always_comb begin
    lead = 5'd0;
    for (int i = 1; i < 31; i++) begin
      if (req.int_value[i]) begin
        lead = 5'(i);
      end
    end
    norm_w  = {req.int_value, 3'b000};
    norm_sh = norm_w >> lead;
    if (req.int_value[30:1] == 30'd0) begin
      from_res = 16'd0;
    end else begin
      from_res = {8'd0, lead, 3'b000} + {10'd0, lead, 1'b0}
               + {12'd0, lcau_pkg::mant_lut(norm_sh[2:0])};
    end
  end

  // cost to integer
  logic [32:0] prod;
  logic [13:0] quot;
  logic [17:0] quot10;
  logic [3:0]  rem, rem_adj;
  logic [63:0] val;
  logic [5:0]  lsh;
  logic [63:0] to_res;
  logic        to_ovf;

  always_comb begin
    prod    = {17'd0, req.cost_a} * {16'd0, lcau_pkg::Recip10};
    quot    = prod[32:lcau_pkg::Recip10Sh];
    quot10  = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
    rem     = 4'(req.cost_a - quot10[15:0]);
    if (rem >= 4'd5) begin
      rem_adj = rem - 4'd2;
    end else if (rem >= 4'd1) begin
      rem_adj = rem - 4'd1;
    end else begin
      rem_adj = rem;
    end
    val    = {60'd0, rem_adj + 4'd8};
    lsh    = quot[5:0] - 6'd3;
    to_ovf = 1'b0;
    if (req.cost_a < 16'd10) begin
      to_res = 64'd1;
    end else if (quot > lcau_pkg::MaxQuot) begin
      to_res = '1;
      to_ovf = 1'b1;
    end else if (quot >= 14'd3) begin
      to_res = val << lsh;
    end else begin
      to_res = val >> (2'd3 - quot[1:0]);
    end
  end

  always_comb begin
    rsp = '0;
    case (req.req_type)
      lcau_pkg::OP_MUL:      rsp.cost_result = req.cost_a + req.cost_b;
      lcau_pkg::OP_ADD:      rsp.cost_result = add_res;
      lcau_pkg::OP_FROM_INT: rsp.cost_result = from_res;
      lcau_pkg::OP_TO_INT: begin
        rsp.int_result = to_res;
        rsp.overflow   = to_ovf;
      end
      default: rsp = '0;
    endcase
  end

endmodule
`default_nettype wire
